### rtl/pocc_pkg.sv
// Shared types and constants for the per-output cursor confinement block.
// Depends on nothing; every other file uses it.
`timescale 1ns / 1ps

package pocc_pkg;

   // Table size and client id width
   localparam int OUTPUT_COUNT = 4;
   localparam int CLIENT_BITS  = 8;
   localparam int IDX_W        = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;

   // Coordinates carry two guard bits so origin + size never wraps
   localparam int CRD_W = 18;

   // Transaction modes
   localparam logic [2:0] MODE_MOVE        = 3'd0;
   localparam logic [2:0] MODE_SET_BOX     = 3'd1;
   localparam logic [2:0] MODE_RESET_BOX   = 3'd2;
   localparam logic [2:0] MODE_QUERY_BOX   = 3'd3;
   localparam logic [2:0] MODE_CLIENT_GONE = 3'd4;
   localparam logic [2:0] MODE_SET_GEOM    = 3'd5;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_VALUE = 2'd1;
   localparam logic [1:0] ST_BAD_MATCH = 2'd2;

   typedef logic signed [CRD_W-1:0] crd_type;
   typedef logic [IDX_W-1:0]        ent_type;
   typedef logic [CLIENT_BITS-1:0]  client_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [1:0]         output_index;
      logic [7:0]         client_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [15:0]        width;
      logic [15:0]        height;
      logic               rotated;
      logic               enabled;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic [15:0]        out_width;
      logic [15:0]        out_height;
      logic               box_active;
      logic               clamped;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic    capture;
      logic    scan;
      logic    exec;
      logic    load;
      ent_type scan_idx;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_mode;
      logic out_free;
   } dp_sts_type;

endpackage

### rtl/pocc_req_if.sv
// Request channel: valid/ready handshake carrying one req_type transaction.
// Depends on pocc_pkg.
`timescale 1ns / 1ps

interface pocc_req_if;
   logic             valid;
   logic             ready;
   pocc_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/pocc_rsp_if.sv
// Response channel: valid/ready handshake carrying one rsp_type transaction.
// Depends on pocc_pkg.
`timescale 1ns / 1ps

interface pocc_rsp_if;
   logic             valid;
   logic             ready;
   pocc_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/pocc_ctrl.sv
// Sequencing state machine: accept, scan the output table or execute once,
// then hand the result to the response register. Depends on pocc_pkg.
`timescale 1ns / 1ps

module pocc_ctrl import pocc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_EXEC   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   localparam ent_type LAST_IDX = IDX_W'(OUTPUT_COUNT - 1);

   state_type state_ff, state_in;
   ent_type   cnt_ff, cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd.capture  = req_valid && req_ready;
      cmd.scan     = (state_ff == S_SCAN);
      cmd.exec     = (state_ff == S_EXEC);
      cmd.load     = (state_ff == S_FINISH) && sts.out_free;
      cmd.scan_idx = cnt_ff;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (cmd.capture) begin
               state_in = sts.scan_mode ? S_SCAN : S_EXEC;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = S_FINISH;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the response register can take the result
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && cnt_ff == LAST_IDX) |=> state_ff == S_FINISH)
      else $error("scan did not end after the last table entry");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && !sts.out_free) |=> state_ff == S_FINISH)
      else $error("result dropped while response register was full");

endmodule

### rtl/pocc_dp.sv
// Datapath: output table, item registers, area and clamp arithmetic and the
// response register. Driven by pocc_ctrl commands. Depends on pocc_pkg.
`timescale 1ns / 1ps

module pocc_dp import pocc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req,
   output rsp_type     rsp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  ctl_cmd_type cmd,
   output dp_sts_type  sts
);

   // Output table
   logic signed [15:0] org_x_ff [OUTPUT_COUNT];
   logic signed [15:0] org_y_ff [OUTPUT_COUNT];
   logic [15:0]        size_w_ff [OUTPUT_COUNT];
   logic [15:0]        size_h_ff [OUTPUT_COUNT];
   logic               rot_ff [OUTPUT_COUNT];
   logic               en_ff [OUTPUT_COUNT];
   logic               box_on_ff [OUTPUT_COUNT];
   crd_type            box_l_ff [OUTPUT_COUNT];
   crd_type            box_t_ff [OUTPUT_COUNT];
   crd_type            box_r_ff [OUTPUT_COUNT];
   crd_type            box_b_ff [OUTPUT_COUNT];
   client_type         owner_ff [OUTPUT_COUNT];

   // Current transaction
   logic [2:0]         mode_ff;
   logic [1:0]         idx_ff;
   client_type         client_ff;
   logic signed [15:0] px_ff, py_ff;
   logic [15:0]        w_ff, h_ff;
   logic               item_rot_ff, item_en_ff;

   // Selected box and partial result
   logic       hit_ff, act_ff;
   logic [1:0] status_ff, status_in;
   crd_type    sel_l_ff, sel_t_ff, sel_r_ff, sel_b_ff;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   ent_type    item_ent, rd_idx;
   logic [15:0] eff_w, eff_h;
   crd_type    x1, y1, x2, y2, px18, py18, bx2, by2;
   logic       in_area, box_fits, scan_hit, gone_match, idx_bad;
   logic       geom_we, box_set_we, box_clr_we, sel_we;
   crd_type    tx, ty, cx, cy;

   assign item_ent = IDX_W'(idx_ff);
   assign rd_idx   = cmd.scan ? cmd.scan_idx : item_ent;

   // Physical area of the addressed entry
   always_comb begin
      eff_w   = rot_ff[rd_idx] ? size_h_ff[rd_idx] : size_w_ff[rd_idx];
      eff_h   = rot_ff[rd_idx] ? size_w_ff[rd_idx] : size_h_ff[rd_idx];
      x1      = {{2{org_x_ff[rd_idx][15]}}, org_x_ff[rd_idx]};
      y1      = {{2{org_y_ff[rd_idx][15]}}, org_y_ff[rd_idx]};
      x2      = x1 + crd_type'({2'b00, eff_w});
      y2      = y1 + crd_type'({2'b00, eff_h});
      px18    = {{2{px_ff[15]}}, px_ff};
      py18    = {{2{py_ff[15]}}, py_ff};
      bx2     = px18 + crd_type'({2'b00, w_ff});
      by2     = py18 + crd_type'({2'b00, h_ff});
      in_area = en_ff[rd_idx] && (px18 >= x1) && (px18 < x2)
                && (py18 >= y1) && (py18 < y2);
      box_fits = en_ff[rd_idx] && (px18 >= x1) && (bx2 <= x2)
                 && (py18 >= y1) && (by2 <= y2);
      scan_hit   = box_on_ff[rd_idx] && in_area;
      gone_match = box_on_ff[rd_idx] && (owner_ff[rd_idx] == client_ff);
   end

   // Decide table writes and status for the current step
   always_comb begin
      idx_bad    = (int'(idx_ff) >= OUTPUT_COUNT);
      status_in  = status_ff;
      geom_we    = 1'b0;
      box_set_we = 1'b0;
      box_clr_we = 1'b0;
      sel_we     = 1'b0;
      if (cmd.scan) begin
         if (mode_ff == MODE_MOVE) begin
            sel_we = scan_hit && !hit_ff;
         end else begin
            box_clr_we = gone_match;
         end
      end else if (cmd.exec) begin
         if (idx_bad && (mode_ff == MODE_SET_BOX || mode_ff == MODE_RESET_BOX
                         || mode_ff == MODE_QUERY_BOX || mode_ff == MODE_SET_GEOM)) begin
            status_in = ST_BAD_VALUE;
         end else begin
            unique case (mode_ff)
               MODE_SET_BOX: begin
                  if (w_ff == '0 || h_ff == '0) begin
                     status_in = ST_BAD_VALUE;
                  end else if (!box_fits) begin
                     status_in = ST_BAD_MATCH;
                  end else begin
                     box_set_we = 1'b1;
                  end
               end
               MODE_RESET_BOX: box_clr_we = 1'b1;
               MODE_QUERY_BOX: sel_we     = 1'b1;
               MODE_SET_GEOM:  geom_we    = 1'b1;
               default: begin
               end
            endcase
         end
      end
   end

   // Table control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OUTPUT_COUNT; i++) begin
            en_ff[i]     <= 1'b0;
            box_on_ff[i] <= 1'b0;
         end
      end else begin
         for (int i = 0; i < OUTPUT_COUNT; i++) begin
            if (rd_idx == IDX_W'(i)) begin
               if (geom_we) begin
                  en_ff[i] <= item_en_ff;
               end
               if (box_set_we) begin
                  box_on_ff[i] <= 1'b1;
               end else if (box_clr_we) begin
                  box_on_ff[i] <= 1'b0;
               end
            end
         end
      end
   end

   // Table payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < OUTPUT_COUNT; i++) begin
         if (rd_idx == IDX_W'(i)) begin
            if (geom_we) begin
               org_x_ff[i]  <= px_ff;
               org_y_ff[i]  <= py_ff;
               size_w_ff[i] <= w_ff;
               size_h_ff[i] <= h_ff;
               rot_ff[i]    <= item_rot_ff;
            end
            if (box_set_we) begin
               box_l_ff[i] <= px18;
               box_t_ff[i] <= py18;
               box_r_ff[i] <= bx2;
               box_b_ff[i] <= by2;
               owner_ff[i] <= client_ff;
            end else if (box_clr_we) begin
               owner_ff[i] <= '0;
            end
         end
      end
   end

   // Transaction registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= req.mode;
         idx_ff      <= req.output_index;
         client_ff   <= CLIENT_BITS'(req.client_id);
         px_ff       <= req.pos_x;
         py_ff       <= req.pos_y;
         w_ff        <= req.width;
         h_ff        <= req.height;
         item_rot_ff <= req.rotated;
         item_en_ff  <= req.enabled;
      end
      if (sel_we) begin
         sel_l_ff <= box_l_ff[rd_idx];
         sel_t_ff <= box_t_ff[rd_idx];
         sel_r_ff <= box_r_ff[rd_idx];
         sel_b_ff <= box_b_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff    <= 1'b0;
         act_ff    <= 1'b0;
         status_ff <= ST_OK;
      end else if (cmd.capture) begin
         hit_ff    <= 1'b0;
         act_ff    <= 1'b0;
         status_ff <= ST_OK;
      end else begin
         status_ff <= status_in;
         if (sel_we && cmd.scan) begin
            hit_ff <= 1'b1;
         end
         if (sel_we && cmd.exec) begin
            act_ff <= box_on_ff[rd_idx];
         end
      end
   end

   // Clamp against the captured box: left/top first, then right/bottom
   always_comb begin
      tx = (px18 < sel_l_ff) ? sel_l_ff : px18;
      ty = (py18 < sel_t_ff) ? sel_t_ff : py18;
      cx = (tx >= sel_r_ff) ? sel_r_ff - crd_type'(1) : tx;
      cy = (ty >= sel_b_ff) ? sel_b_ff - crd_type'(1) : ty;
   end

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = status_ff;
      if (mode_ff == MODE_MOVE) begin
         if (hit_ff) begin
            rsp_in.out_x   = cx[15:0];
            rsp_in.out_y   = cy[15:0];
            rsp_in.clamped = (cx != px18) || (cy != py18);
         end else begin
            rsp_in.out_x = px_ff;
            rsp_in.out_y = py_ff;
         end
      end else if (mode_ff == MODE_QUERY_BOX && act_ff) begin
         rsp_in.box_active = 1'b1;
         rsp_in.out_x      = sel_l_ff[15:0];
         rsp_in.out_y      = sel_t_ff[15:0];
         rsp_in.out_width  = 16'(sel_r_ff - sel_l_ff);
         rsp_in.out_height = 16'(sel_b_ff - sel_t_ff);
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp           = rsp_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign sts.scan_mode = (req.mode == MODE_MOVE) || (req.mode == MODE_CLIENT_GONE);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   a_set_arms: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && box_set_we) |=> box_on_ff[$past(rd_idx)])
      else $error("accepted box not active on its output");

   a_gone_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && mode_ff == MODE_CLIENT_GONE)
      |=> !(box_on_ff[$past(rd_idx)] && owner_ff[$past(rd_idx)] == client_ff))
      else $error("box of departed client survived the scan");

   a_clamp_inside: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && mode_ff == MODE_MOVE && hit_ff)
      |-> (cx >= sel_l_ff && cx < sel_r_ff && cy >= sel_t_ff && cy < sel_b_ff))
      else $error("clamped point lies outside the confine box");

endmodule

### rtl/per_output_cursor_confine_clamp.sv
// Per-output cursor confinement: top level joining controller and datapath.
// Depends on pocc_pkg, pocc_req_if, pocc_rsp_if, pocc_ctrl and pocc_dp.
//
// The request channel carries one transaction per item: move a pointer,
// set, reset or query an output's confine box, drop all boxes of a
// departed client, or set an output's geometry. Every request gives
// exactly one response transaction on the response channel.
//
// Move and client-gone walk the output table one entry a cycle; all
// other modes execute once. The table walk uses a single shared
// area/clamp unit. One request is in progress at a time; the next is
// accepted the cycle after the previous result enters the response
// register.
//
// Reset (synchronous, active high) disables every output, deactivates
// every box and empties the response register. If the receiver stalls,
// the response is held in its register and the finished request waits;
// no new request is taken until it moves on.
`timescale 1ns / 1ps

module per_output_cursor_confine_clamp import pocc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pocc_req_if.sink          req_if,
   pocc_rsp_if.source        rsp_if
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;
   logic        ready;

   assign req_if.ready = ready;

   pocc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pocc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.payload),
      .rsp       (rsp_if.payload),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

### dv/tb_top.sv
// Self-checking testbench for per_output_cursor_confine_clamp: a directed table, then random
// transactions, each response checked against a fixed value or an in-bench model of the output table.
// Depends on pocc_pkg, pocc_req_if, pocc_rsp_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
   import pocc_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1525;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pocc_req_if req_ch ();
   pocc_rsp_if rsp_ch ();

   per_output_cursor_confine_clamp u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #2 clock = ~clock;

   // Model of the output table
   logic signed [15:0] geo_x   [OUTPUT_COUNT] = '{default: '0};
   logic signed [15:0] geo_y   [OUTPUT_COUNT] = '{default: '0};
   logic [15:0]        geo_w   [OUTPUT_COUNT] = '{default: '0};
   logic [15:0]        geo_h   [OUTPUT_COUNT] = '{default: '0};
   logic               geo_rot [OUTPUT_COUNT] = '{default: '0};
   logic               geo_en  [OUTPUT_COUNT] = '{default: '0};
   logic               box_live[OUTPUT_COUNT] = '{default: '0};
   crd_type            box_l   [OUTPUT_COUNT] = '{default: '0};
   crd_type            box_t   [OUTPUT_COUNT] = '{default: '0};
   crd_type            box_r   [OUTPUT_COUNT] = '{default: '0};
   crd_type            box_b   [OUTPUT_COUNT] = '{default: '0};
   client_type         box_who [OUTPUT_COUNT] = '{default: '0};

   rsp_type      due_rsp[$];
   stim_row_type stim[$];
   int           fail_count  = 0;
   int           idle_cycles = 0;
   int           src_idle    = 0;
   int           sink_idle   = 0;

   function automatic bit phys_area(int i, output int x1, output int y1,
                                    output int x2, output int y2);
      int w;
      int h;
      w  = geo_rot[i] ? int'(geo_h[i]) : int'(geo_w[i]);
      h  = geo_rot[i] ? int'(geo_w[i]) : int'(geo_h[i]);
      x1 = int'(geo_x[i]);
      y1 = int'(geo_y[i]);
      x2 = x1 + w;
      y2 = y1 + h;
      return geo_en[i];
   endfunction

   function automatic rsp_type confine_predict(req_type r);
      rsp_type a;
      int      px;
      int      py;
      int      ox;
      int      oy;
      int      x1;
      int      y1;
      int      x2;
      int      y2;
      int      bx2;
      int      by2;
      int      idx;
      bit      on;
      bit      hit;
      a   = '0;
      px  = int'(r.pos_x);
      py  = int'(r.pos_y);
      idx = int'(r.output_index);
      if (r.mode != MODE_MOVE && r.mode != MODE_CLIENT_GONE && r.mode <= MODE_SET_GEOM &&
          idx >= OUTPUT_COUNT) begin
         a.status = ST_BAD_VALUE;
      end else begin
         case (r.mode)
            MODE_MOVE: begin
               ox  = px;
               oy  = py;
               hit = 1'b0;
               for (int i = 0; i < OUTPUT_COUNT && !hit; i++) begin
                  on = phys_area(i, x1, y1, x2, y2);
                  if (box_live[i] && on && px >= x1 && px < x2 && py >= y1 && py < y2) begin
                     hit = 1'b1;
                     if (ox < box_l[i]) ox = int'(box_l[i]);
                     if (ox >= box_r[i]) ox = box_r[i] - 1;
                     if (oy < box_t[i]) oy = int'(box_t[i]);
                     if (oy >= box_b[i]) oy = box_b[i] - 1;
                     a.clamped = (ox != px || oy != py);
                  end
               end
               a.out_x = ox[15:0];
               a.out_y = oy[15:0];
            end
            MODE_SET_BOX: begin
               bx2 = px + int'(r.width);
               by2 = py + int'(r.height);
               on  = phys_area(idx, x1, y1, x2, y2);
               if (r.width == 0 || r.height == 0) begin
                  a.status = ST_BAD_VALUE;
               end else if (!on || px < x1 || bx2 > x2 || py < y1 || by2 > y2) begin
                  a.status = ST_BAD_MATCH;
               end else begin
                  box_live[idx] = 1'b1;
                  box_who[idx]  = r.client_id[CLIENT_BITS-1:0];
                  box_l[idx]    = CRD_W'(px);
                  box_t[idx]    = CRD_W'(py);
                  box_r[idx]    = CRD_W'(bx2);
                  box_b[idx]    = CRD_W'(by2);
               end
            end
            MODE_RESET_BOX: begin
               box_live[idx] = 1'b0;
               box_who[idx]  = '0;
            end
            MODE_QUERY_BOX: begin
               if (box_live[idx]) begin
                  ox           = int'(box_r[idx] - box_l[idx]);
                  oy           = int'(box_b[idx] - box_t[idx]);
                  a.box_active = 1'b1;
                  a.out_x      = box_l[idx][15:0];
                  a.out_y      = box_t[idx][15:0];
                  a.out_width  = ox[15:0];
                  a.out_height = oy[15:0];
               end
            end
            MODE_CLIENT_GONE: begin
               for (int i = 0; i < OUTPUT_COUNT; i++) begin
                  if (box_live[i] && box_who[i] == r.client_id[CLIENT_BITS-1:0]) begin
                     box_live[i] = 1'b0;
                     box_who[i]  = '0;
                  end
               end
            end
            MODE_SET_GEOM: begin
               geo_x[idx]   = r.pos_x;
               geo_y[idx]   = r.pos_y;
               geo_w[idx]   = r.width;
               geo_h[idx]   = r.height;
               geo_rot[idx] = r.rotated;
               geo_en[idx]  = r.enabled;
            end
            default: ;
         endcase
      end
      return a;
   endfunction

   function automatic req_type mk_req(logic [2:0] m, int idx, int cid,
                                      int x, int y, int w, int h, int rot, int en);
      req_type r;
      r.mode         = m;
      r.output_index = idx[1:0];
      r.client_id    = cid[7:0];
      r.pos_x        = x[15:0];
      r.pos_y        = y[15:0];
      r.width        = w[15:0];
      r.height       = h[15:0];
      r.rotated      = rot[0];
      r.enabled      = en[0];
      return r;
   endfunction

   function automatic rsp_type mk_rsp(logic [1:0] st, int x, int y, int w, int h,
                                      int act, int clp);
      rsp_type a;
      a.status     = st;
      a.out_x      = x[15:0];
      a.out_y      = y[15:0];
      a.out_width  = w[15:0];
      a.out_height = h[15:0];
      a.box_active = act[0];
      a.clamped    = clp[0];
      return a;
   endfunction

   function automatic void fill_table();
      rsp_type none;
      none = '0;
      // nothing is confined straight after reset
      stim.push_back('{mk_req(MODE_QUERY_BOX, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
      stim.push_back('{mk_req(MODE_MOVE, 0, 0, -32768, 32767, 0, 0, 0, 0), 1'b1,
                       mk_rsp(ST_OK, -32768, 32767, 0, 0, 0, 0)});
      stim.push_back('{mk_req(MODE_MOVE, 3, 255, 32767, -32768, 65535, 65535, 1, 1), 1'b1,
                       mk_rsp(ST_OK, 32767, -32768, 0, 0, 0, 0)});
      stim.push_back('{mk_req(MODE_SET_BOX, 1, 3, 0, 0, 0, 10, 0, 0), 1'b1,
                       mk_rsp(ST_BAD_VALUE, 0, 0, 0, 0, 0, 0)});
      stim.push_back('{mk_req(MODE_SET_BOX, 1, 3, 0, 0, 10, 0, 0, 0), 1'b1,
                       mk_rsp(ST_BAD_VALUE, 0, 0, 0, 0, 0, 0)});
      stim.push_back('{mk_req(MODE_SET_BOX, 0, 3, 0, 0, 10, 10, 0, 0), 1'b1,
                       mk_rsp(ST_BAD_MATCH, 0, 0, 0, 0, 0, 0)});
      stim.push_back('{mk_req(MODE_SPARE_6, 2, 17, 5, 5, 5, 5, 1, 1), 1'b1, none});
      stim.push_back('{mk_req(MODE_SPARE_7, 3, 255, -1, -1, 65535, 65535, 1, 1), 1'b1, none});
      stim.push_back('{mk_req(MODE_SET_GEOM, 0, 0, 0, 0, 1920, 1080, 0, 1), 1'b0, none});
      // quarter turn: mode 1080x1920 shows as 1920x1080
      stim.push_back('{mk_req(MODE_SET_GEOM, 1, 0, 1920, 0, 1080, 1920, 1, 1), 1'b0, none});
      stim.push_back('{mk_req(MODE_SET_GEOM, 2, 0, 32767, 32767, 65535, 65535, 0, 1),
                       1'b0, none});
      stim.push_back('{mk_req(MODE_SET_GEOM, 3, 0, -32768, -32768, 65535, 65535, 1, 0),
                       1'b0, none});
      stim.push_back('{mk_req(MODE_SET_BOX, 0, 5, 100, 100, 200, 100, 0, 0), 1'b0, none});
      stim.push_back('{mk_req(MODE_SET_BOX, 1, 5, 3000, 0, 1000, 10, 0, 0), 1'b1,
                       mk_rsp(ST_BAD_MATCH, 0, 0, 0, 0, 0, 0)});
      stim.push_back('{mk_req(MODE_MOVE, 0, 0, 10, 10, 0, 0, 0, 0), 1'b0, none});
      stim.push_back('{mk_req(MODE_MOVE, 0, 0, 1919, 1079, 0, 0, 0, 0), 1'b0, none});
      stim.push_back('{mk_req(MODE_SET_BOX, 1, 7, 1920, 0, 1920, 1080, 0, 0), 1'b0, none});
      stim.push_back('{mk_req(MODE_SET_BOX, 0, 9, 0, 0, 10, 10, 0, 0), 1'b0, none});
      stim.push_back('{mk_req(MODE_QUERY_BOX, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
      // shrink output 0 under its box; the box must survive
      stim.push_back('{mk_req(MODE_SET_GEOM, 0, 0, 0, 0, 5, 5, 0, 1), 1'b0, none});
      stim.push_back('{mk_req(MODE_MOVE, 0, 0, 4, 4, 0, 0, 0, 0), 1'b0, none});
      stim.push_back('{mk_req(MODE_SET_BOX, 2, 255, 32767, 32767, 65535, 65535, 0, 0),
                       1'b0, none});
      stim.push_back('{mk_req(MODE_MOVE, 0, 0, 32767, 32767, 0, 0, 0, 0), 1'b0, none});
      stim.push_back('{mk_req(MODE_CLIENT_GONE, 0, 9, 0, 0, 0, 0, 0, 0), 1'b0, none});
      stim.push_back('{mk_req(MODE_RESET_BOX, 3, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
      stim.push_back('{mk_req(MODE_MOVE, 0, 0, 1000, 2000, 0, 0, 0, 0), 1'b0, none});
   endfunction

   // Mostly well-formed transactions aimed at the live areas and boxes, the rest noise
   function automatic req_type pick_item();
      req_type r;
      int      sel;
      int      i;
      int      x1;
      int      y1;
      int      x2;
      int      y2;
      int      bw;
      int      bh;
      int      x;
      int      y;
      bit      on;
      r.mode         = MODE_MOVE;
      r.output_index = 2'($urandom);
      r.client_id    = 8'($urandom);
      r.pos_x        = 16'($urandom);
      r.pos_y        = 16'($urandom);
      r.width        = 16'($urandom);
      r.height       = 16'($urandom);
      r.rotated      = 1'($urandom);
      r.enabled      = 1'($urandom);
      i   = int'(r.output_index);
      sel = $urandom_range(0, 99);
      on  = phys_area(i, x1, y1, x2, y2);
      if ($urandom_range(0, 3) != 0) r.client_id = 8'($urandom_range(0, 3));
      if (sel < 10) begin
         r.mode = MODE_SET_GEOM;
         if ($urandom_range(0, 7) != 0) begin
            x           = $urandom_range(0, 4000);
            y           = $urandom_range(0, 4000);
            r.pos_x     = 16'(x - 2000);
            r.pos_y     = 16'(y - 2000);
            r.width     = 16'($urandom_range(1, 3000));
            r.height    = 16'($urandom_range(1, 3000));
            r.enabled   = ($urandom_range(0, 5) != 0);
         end
      end else if (sel < 38) begin
         r.mode = MODE_SET_BOX;
         if (on && x2 > x1 && y2 > y1 && $urandom_range(0, 9) < 8) begin
            bw       = $urandom_range(1, x2 - x1);
            bh       = $urandom_range(1, y2 - y1);
            x        = x1 + $urandom_range(0, x2 - x1 - bw);
            y        = y1 + $urandom_range(0, y2 - y1 - bh);
            r.pos_x  = x[15:0];
            r.pos_y  = y[15:0];
            r.width  = bw[15:0];
            r.height = bh[15:0];
         end else if ($urandom_range(0, 3) == 0) begin
            if (r.rotated) r.width = '0;
            else r.height = '0;
         end
      end else if (sel < 70) begin
         r.mode = MODE_MOVE;
         if (box_live[i] && $urandom_range(0, 9) < 6) begin
            x       = box_l[i] - 8 + $urandom_range(0, box_r[i] - box_l[i] + 15);
            y       = box_t[i] - 8 + $urandom_range(0, box_b[i] - box_t[i] + 15);
            r.pos_x = x[15:0];
            r.pos_y = y[15:0];
         end else if (on && $urandom_range(0, 3) != 0) begin
            x       = x1 + $urandom_range(0, x2 - x1);
            y       = y1 + $urandom_range(0, y2 - y1);
            r.pos_x = x[15:0];
            r.pos_y = y[15:0];
         end
      end else if (sel < 84) begin
         r.mode = MODE_QUERY_BOX;
      end else if (sel < 90) begin
         r.mode = MODE_RESET_BOX;
      end else if (sel < 96) begin
         r.mode = MODE_CLIENT_GONE;
         if ($urandom_range(0, 3) != 0) r.client_id = box_who[i];
      end else begin
         r.mode = 3'($urandom_range(MODE_SPARE_6, MODE_SPARE_7));
      end
      return r;
   endfunction

   task automatic send_item(req_type r, bit typed, rsp_type fixed);
      rsp_type p;
      while ($urandom_range(0, 99) < src_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      // predict at the accepting edge so the table stays in step with the block
      p = confine_predict(r);
      due_rsp.push_back(typed ? fixed : p);
   endtask

   function automatic void check_rsp(rsp_type got);
      rsp_type want;
      if (due_rsp.size() == 0) begin
         $error("response transaction with none outstanding");
         fail_count++;
         return;
      end
      want = due_rsp.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         fail_count++;
      end
      if (got.out_x !== want.out_x) begin
         $error("out_x: expected %0d, got %0d", want.out_x, got.out_x);
         fail_count++;
      end
      if (got.out_y !== want.out_y) begin
         $error("out_y: expected %0d, got %0d", want.out_y, got.out_y);
         fail_count++;
      end
      if (got.out_width !== want.out_width) begin
         $error("out_width: expected %0d, got %0d", want.out_width, got.out_width);
         fail_count++;
      end
      if (got.out_height !== want.out_height) begin
         $error("out_height: expected %0d, got %0d", want.out_height, got.out_height);
         fail_count++;
      end
      if (got.box_active !== want.box_active) begin
         $error("box_active: expected %0d, got %0d", want.box_active, got.box_active);
         fail_count++;
      end
      if (got.clamped !== want.clamped) begin
         $error("clamped: expected %0d, got %0d", want.clamped, got.clamped);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_rsp(rsp_ch.payload);
         rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle);
      end
   end

   // Abort when no transaction moves on either channel for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rsp_type none;
      none = '0;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      fill_table();
      repeat (4) @(posedge clock);
      reset     <= 1'b0;
      src_idle  = 7;
      sink_idle = 68;
      foreach (stim[k]) send_item(stim[k].req, stim[k].typed, stim[k].rsp);
      for (int phase = 0; phase < 3; phase++) begin
         src_idle  = (phase == 0) ? 7 : (phase == 1) ? 68 : 0;
         sink_idle = (phase == 0) ? 68 : (phase == 1) ? 7 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_item(pick_item(), 1'b0, none);
      end
      req_ch.valid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
